>>> design/lpfp_pkg.sv
// ----------------------------------------------------------------------------
// lpfp_pkg: shared types and codes of the length-prefixed frame parser
// Beat structs, action and register codes, one-hot parser states.
// ----------------------------------------------------------------------------
package lpfp_pkg;

  localparam logic [1:0] ACT_FEED    = 2'd0;
  localparam logic [1:0] ACT_RESTART = 2'd1;
  localparam logic [1:0] ACT_READ    = 2'd2;

  localparam logic [1:0] CFG_HEADER = 2'd0;
  localparam logic [1:0] CFG_FOOTER = 2'd1;

  localparam logic [7:0] HEADER_RESET = 8'd254;
  localparam logic [7:0] FOOTER_RESET = 8'd250;

  localparam logic [7:0] SIZE_OVERHEAD = 8'd2;
  localparam logic [8:0] MAX_FILL      = 9'd253;

  localparam logic [2:0] PH_HDR1 = 3'd0;
  localparam logic [2:0] PH_HDR2 = 3'd1;
  localparam logic [2:0] PH_SIZE = 3'd2;
  localparam logic [2:0] PH_ID   = 3'd3;
  localparam logic [2:0] PH_DATA = 3'd4;
  localparam logic [2:0] PH_FOOT = 3'd5;
  localparam logic [2:0] PH_DONE = 3'd6;

  typedef enum logic [6:0] {
    ST_HDR1 = 7'b0000001,
    ST_HDR2 = 7'b0000010,
    ST_SIZE = 7'b0000100,
    ST_ID   = 7'b0001000,
    ST_DATA = 7'b0010000,
    ST_FOOT = 7'b0100000,
    ST_DONE = 7'b1000000
  } state_t;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] data_byte;
    logic [7:0] read_index;
  } in_beat_t;

  typedef struct packed {
    logic [2:0] phase;
    logic       finished;
    logic [7:0] frame_size;
    logic [7:0] command_code;
    logic       footer_error;
    logic       byte_ignored;
    logic       read_valid;
    logic [7:0] read_byte;
  } out_beat_t;

  typedef struct packed {
    logic [7:0] header_value;
    logic [7:0] footer_value;
  } cfg_t;

  typedef struct packed {
    logic       en;
    logic [7:0] addr;
    logic [7:0] data;
  } mem_wr_t;

  typedef struct packed {
    logic       en;
    logic [7:0] addr;
  } mem_rd_t;

  function automatic logic [2:0] phase_of(state_t st);
    logic [2:0] ph;
    case (st)
      ST_HDR1: ph = PH_HDR1;
      ST_HDR2: ph = PH_HDR2;
      ST_SIZE: ph = PH_SIZE;
      ST_ID:   ph = PH_ID;
      ST_DATA: ph = PH_DATA;
      ST_FOOT: ph = PH_FOOT;
      ST_DONE: ph = PH_DONE;
      default: ph = PH_HDR1;
    endcase
    return ph;
  endfunction

endpackage

>>> design/lpfp_store.sv
// ----------------------------------------------------------------------------
// lpfp_store: payload byte memory
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module lpfp_store #(
  parameter int PAYLOAD_DEPTH = 256
) (
  input  logic              clk,
  input  lpfp_pkg::mem_wr_t wr,
  input  lpfp_pkg::mem_rd_t rd,
  output logic [7:0]        rd_data
);

  localparam int AW = $clog2(PAYLOAD_DEPTH);

  logic [7:0] mem [PAYLOAD_DEPTH];
  logic [7:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr[AW-1:0]] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd.en) begin
      rd_data_r <= mem[rd.addr[AW-1:0]];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> design/lpfp_ctrl.sv
// ----------------------------------------------------------------------------
// lpfp_ctrl: frame phase machine
// Tracks header, size, id, payload and footer; drives the store ports.
// ----------------------------------------------------------------------------
module lpfp_ctrl #(
  parameter int PAYLOAD_DEPTH = 256
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                fire,
  input  lpfp_pkg::in_beat_t  beat,
  input  lpfp_pkg::cfg_t      cfg,
  output lpfp_pkg::out_beat_t res,
  output lpfp_pkg::mem_wr_t   wr,
  output lpfp_pkg::mem_rd_t   rd
);

  localparam int AW = $clog2(PAYLOAD_DEPTH);
  localparam logic [AW-1:0] WPTR_LAST = AW'(PAYLOAD_DEPTH - 1);
  localparam logic [8:0]    DEPTH9    = 9'(PAYLOAD_DEPTH);

  lpfp_pkg::state_t state_r, state_nxt;
  logic [7:0]    size_r, size_nxt;
  logic [7:0]    id_r, id_nxt;
  logic [8:0]    fill_r, fill_nxt;
  logic [AW-1:0] wptr_r, wptr_nxt;
  logic          ferr, ign, rvalid;
  logic [8:0]    fill_inc;
  logic [8:0]    ridx9;

  always_comb begin
    state_nxt = state_r;
    size_nxt  = size_r;
    id_nxt    = id_r;
    fill_nxt  = fill_r;
    wptr_nxt  = wptr_r;
    ferr      = 1'b0;
    ign       = 1'b0;
    rvalid    = 1'b0;
    wr        = '0;
    rd        = '0;
    fill_inc  = fill_r + 9'd1;
    ridx9     = {1'b0, beat.read_index};
    if (fire) begin
      case (beat.action)
        lpfp_pkg::ACT_FEED: begin
          unique case (state_r)
            lpfp_pkg::ST_HDR1: begin
              state_nxt = (beat.data_byte == cfg.header_value) ?
                          lpfp_pkg::ST_HDR2 : lpfp_pkg::ST_HDR1;
            end
            lpfp_pkg::ST_HDR2: begin
              state_nxt = (beat.data_byte == cfg.header_value) ?
                          lpfp_pkg::ST_SIZE : lpfp_pkg::ST_HDR1;
            end
            lpfp_pkg::ST_SIZE: begin
              size_nxt  = beat.data_byte;
              state_nxt = lpfp_pkg::ST_ID;
            end
            lpfp_pkg::ST_ID: begin
              id_nxt    = beat.data_byte;
              fill_nxt  = '0;
              wptr_nxt  = '0;
              state_nxt = (size_r <= lpfp_pkg::SIZE_OVERHEAD) ?
                          lpfp_pkg::ST_FOOT : lpfp_pkg::ST_DATA;
            end
            lpfp_pkg::ST_DATA: begin
              wr.en    = 1'b1;
              wr.addr  = 8'(wptr_r);
              wr.data  = beat.data_byte;
              fill_nxt = fill_inc;
              wptr_nxt = (wptr_r == WPTR_LAST) ? '0 : wptr_r + AW'(1);
              if (size_r <= lpfp_pkg::SIZE_OVERHEAD ||
                  fill_inc >= {1'b0, size_r - lpfp_pkg::SIZE_OVERHEAD}) begin
                state_nxt = lpfp_pkg::ST_FOOT;
              end
            end
            lpfp_pkg::ST_FOOT: begin
              if (beat.data_byte == cfg.footer_value) begin
                state_nxt = lpfp_pkg::ST_DONE;
              end else begin
                ferr      = 1'b1;
                state_nxt = lpfp_pkg::ST_HDR1;
              end
            end
            lpfp_pkg::ST_DONE: begin
              ign = 1'b1;
            end
            default: begin
              state_nxt = lpfp_pkg::ST_HDR1;
            end
          endcase
        end
        lpfp_pkg::ACT_RESTART: begin
          state_nxt = lpfp_pkg::ST_HDR1;
          size_nxt  = '0;
          id_nxt    = '0;
          fill_nxt  = '0;
          wptr_nxt  = '0;
        end
        lpfp_pkg::ACT_READ: begin
          if (ridx9 < fill_r && ridx9 < DEPTH9) begin
            rvalid  = 1'b1;
            rd.en   = 1'b1;
            rd.addr = beat.read_index;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    res              = '0;
    res.phase        = lpfp_pkg::phase_of(state_nxt);
    res.finished     = (state_nxt == lpfp_pkg::ST_DONE);
    res.frame_size   = size_nxt;
    res.command_code = id_nxt;
    res.footer_error = ferr;
    res.byte_ignored = ign;
    res.read_valid   = rvalid;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lpfp_pkg::ST_HDR1;
      size_r  <= '0;
      id_r    <= '0;
      fill_r  <= '0;
      wptr_r  <= '0;
    end else begin
      state_r <= state_nxt;
      size_r  <= size_nxt;
      id_r    <= id_nxt;
      fill_r  <= fill_nxt;
      wptr_r  <= wptr_nxt;
    end
  end

  a_wr_in_data: assert property (@(posedge clk) disable iff (!rst_n)
    wr.en |-> state_r == lpfp_pkg::ST_DATA)
    else $error("payload write outside payload phase");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= lpfp_pkg::MAX_FILL)
    else $error("fill count beyond largest payload");

  a_wptr_bound: assert property (@(posedge clk) disable iff (!rst_n)
    wptr_r <= WPTR_LAST)
    else $error("write pointer beyond store depth");

  a_read_window: assert property (@(posedge clk) disable iff (!rst_n)
    rd.en |-> {1'b0, rd.addr} < fill_r && !wr.en)
    else $error("store read outside received payload");

endmodule

>>> design/length_prefixed_frame_parser_top.sv
// ----------------------------------------------------------------------------
// length_prefixed_frame_parser_top: length-prefixed frame parser
// Feeds serial bytes through a header/size/id/payload/footer phase machine,
// stores the payload in a byte memory and serves indexed reads of it.
//
// Input beats (in_valid/in_ready/in_data) carry an action: feed a byte,
// restart the parser, or read a stored payload byte. Each accepted beat
// yields exactly one result beat on out_valid/out_ready/out_data, in order.
// The result of a beat accepted at one edge is shown from the next cycle,
// with the payload read data taken straight from the registered memory
// read port. Throughput is one beat per cycle while the output is not
// stalled; the phase update and the single store write or read fit in the
// accepting cycle. A stalled result holds in the output register; a new beat
// is taken in the same cycle the held result leaves, so in_ready follows
// out_ready when the output register is full.
// cfg_wr_en/cfg_index/cfg_wdata write the header value (index 0) and the
// footer value (index 1); other indexes are dropped.
// Reset (rst_n low at a clock edge) returns the parser to header hunting,
// clears size, id and fill count, and restores header 254 and footer 250.
// The payload memory is not cleared; reads never reach unwritten entries.
// ----------------------------------------------------------------------------
module length_prefixed_frame_parser_top #(
  parameter int PAYLOAD_DEPTH = 256
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  lpfp_pkg::in_beat_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output lpfp_pkg::out_beat_t out_data,
  input  logic                cfg_wr_en,
  input  logic [1:0]          cfg_index,
  input  logic [7:0]          cfg_wdata
);

  lpfp_pkg::cfg_t      cfg_r;
  lpfp_pkg::out_beat_t res;
  lpfp_pkg::out_beat_t res_r;
  lpfp_pkg::mem_wr_t   wr;
  lpfp_pkg::mem_rd_t   rd;
  logic                res_valid_r;
  logic                fire;
  logic [7:0]          rd_data;

  assign in_ready = !res_valid_r || out_ready;
  assign fire     = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.header_value <= lpfp_pkg::HEADER_RESET;
      cfg_r.footer_value <= lpfp_pkg::FOOTER_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        lpfp_pkg::CFG_HEADER: cfg_r.header_value <= cfg_wdata;
        lpfp_pkg::CFG_FOOTER: cfg_r.footer_value <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  lpfp_ctrl #(
    .PAYLOAD_DEPTH(PAYLOAD_DEPTH)
  ) u_ctrl (
    .clk  (clk),
    .rst_n(rst_n),
    .fire (fire),
    .beat (in_data),
    .cfg  (cfg_r),
    .res  (res),
    .wr   (wr),
    .rd   (rd)
  );

  lpfp_store #(
    .PAYLOAD_DEPTH(PAYLOAD_DEPTH)
  ) u_store (
    .clk    (clk),
    .wr     (wr),
    .rd     (rd),
    .rd_data(rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
    end else if (in_ready) begin
      res_valid_r <= fire;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_r <= res;
    end
  end

  always_comb begin
    out_data           = res_r;
    out_data.read_byte = res_r.read_valid ? rd_data : 8'd0;
  end

  assign out_valid = res_valid_r;

  a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.read_valid |-> !out_data.footer_error && !out_data.byte_ignored)
    else $error("read result carries feed flags");

  a_done_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.byte_ignored |-> out_data.finished)
    else $error("ignored byte without finished frame");

endmodule
